// ===== hdl/tusa_pkg.sv =====
package tusa_pkg;

  // Default table size.
  localparam int unsigned SLOT_COUNT_DEF = 16;

  // Field widths.
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned OBJ_W    = 16;
  localparam int unsigned UNIT_W   = 4;
  localparam int unsigned SIDX_W   = 4;
  localparam int unsigned MASK_W   = 16;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned STATUS_W = 3;

  // Stream widths.
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned S_TUSER_W = 4;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned M_TUSER_W = 5;

  // Request function codes.
  localparam logic [FUNC_W-1:0] FUNC_BIND        = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_UNBIND_TEX  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_UNBIND_SLOT = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNBIND_ALL  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_STALE_SLOT  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_STALE_ALL   = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_NEW      = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOTBOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_INVALID  = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_DONE     = 3'd5;

endpackage

// ===== hdl/texture_unit_slot_allocator.sv =====
// Channel   | Direction | Handshake                    | Contents (lowest bit first)
// ----------+-----------+------------------------------+-------------------------------------
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata: texture_id, object_id,
//           |           |                              |   target_slot; tuser: func, kind
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata: unit, evicted_id,
//           |           |                              |   bind_object; tuser: status,
//           |           |                              |   evicted_valid, bind_kind
// cfg       | in        | cfg_we_i                     | cfg_wdata_i: reserved_mask
//
// Slot operations, stale and invalid handles go straight from idle to the result state.
// Bind and unbind by texture walk the tag memory one slot a cycle through a single
// comparator; a bind that misses then searches for a free slot, stepping once a cycle
// from one past the pointer.
// Reset is asynchronous and active low; it clears all marks, the pointer and the mask.
// A new request is taken only when the sequencer is idle; one finished result may wait
// in the output register while the next request is being worked on.
module texture_unit_slot_allocator #(
  parameter int unsigned SLOT_COUNT = tusa_pkg::SLOT_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tusa_pkg::MASK_W-1:0]    cfg_wdata_i,   // reserved_mask
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // texture_id [15:0], object_id [31:16], target_slot [35:32], zero pad
  input  logic [tusa_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // func [2:0], texture_kind [3]
  input  logic [tusa_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // unit [3:0], evicted_id [19:4], bind_object [35:20], zero pad
  output logic [tusa_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // status [2:0], evicted_valid [3], bind_kind [4]
  output logic [tusa_pkg::M_TUSER_W-1:0] m_axis_tuser
);
  import tusa_pkg::*;

  localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0]  SLOT_CNT  = CNT_W'(SLOT_COUNT);
  localparam logic [CNT_W-1:0]  LAST_TRY  = CNT_W'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_FREE, ST_EVRD, ST_COMMIT, ST_RESP
  } state_e;

  state_e                  state_q;
  logic [MASK_W-1:0]       mask_q;
  logic [FUNC_W-1:0]       func_q;
  logic [TAG_W-1:0]        id_q;
  logic                    kind_q;
  logic [OBJ_W-1:0]        obj_q;
  logic [SLOT_COUNT-1:0]   bound_q;
  logic [SLOT_COUNT-1:0]   fresh_q;
  logic [SLOT_COUNT-1:0]   dup_q;
  logic [SLOT_W-1:0]       ptr_q;
  logic [SLOT_W-1:0]       cand_q;
  logic [SLOT_W-1:0]       cmp_idx_q;
  logic                    cmp_vld_q;
  logic [CNT_W-1:0]        issue_q;
  logic [CNT_W-1:0]        tried_q;
  logic [TAG_W-1:0]        rdata_q;
  logic [UNIT_W-1:0]       res_unit_q;
  logic [STATUS_W-1:0]     res_status_q;
  logic                    res_evv_q;
  logic [TAG_W-1:0]        res_evid_q;
  logic [OBJ_W-1:0]        res_obj_q;
  logic                    res_kind_q;
  logic                    m_valid_q;
  logic [M_TDATA_W-1:0]    m_data_q;
  logic [M_TUSER_W-1:0]    m_user_q;

  // Tag memory: one write and one registered read per cycle.
  logic [TAG_W-1:0]        tag_mem [SLOT_COUNT];

  // Unpacked request fields.
  logic [FUNC_W-1:0]       in_func;
  logic [TAG_W-1:0]        in_id;
  logic                    in_kind;
  logic [OBJ_W-1:0]        in_obj;
  logic [SIDX_W-1:0]       in_sidx;
  logic [SLOT_W-1:0]       in_slot;
  logic                    in_range;
  logic                    accept;

  logic [SLOT_COUNT-1:0]   res_vec;
  logic [SLOT_COUNT-1:0]   cand_onehot;
  logic                    tag_re;
  logic [SLOT_W-1:0]       tag_raddr;
  logic                    match;
  logic                    scan_last;
  logic                    cand_ok;
  logic [SLOT_W-1:0]       cand_next;
  logic [SLOT_W-1:0]       ptr_next;
  logic                    out_free;

  assign in_id    = s_axis_tdata[15:0];
  assign in_obj   = s_axis_tdata[31:16];
  assign in_sidx  = s_axis_tdata[35:32];
  assign in_func  = s_axis_tuser[2:0];
  assign in_kind  = s_axis_tuser[3];
  assign in_slot  = SLOT_W'(in_sidx);
  assign in_range = (32'(in_sidx) < SLOT_COUNT);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign out_free      = !m_valid_q || m_axis_tready;

  // Only the first MASK_W slots can be reserved.
  for (genvar gi = 0; gi < SLOT_COUNT; gi++) begin : g_res
    if (gi < MASK_W) begin : g_mask
      assign res_vec[gi] = mask_q[gi];
    end else begin : g_none
      assign res_vec[gi] = 1'b0;
    end
  end

  // Read address: scan pointer while searching, the chosen slot before commit.
  assign tag_re    = ((state_q == ST_SCAN) && (issue_q < SLOT_CNT)) || (state_q == ST_EVRD);
  assign tag_raddr = (state_q == ST_EVRD) ? cand_q : issue_q[SLOT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (state_q == ST_COMMIT) begin
      tag_mem[cand_q] <= id_q;
    end
    if (tag_re) begin
      rdata_q <= tag_mem[tag_raddr];
    end
  end

  // Shared comparator and round-robin stepping.
  assign match       = cmp_vld_q && bound_q[cmp_idx_q] && (rdata_q == id_q);
  assign scan_last   = cmp_vld_q && (cmp_idx_q == LAST_SLOT);
  assign cand_ok     = !fresh_q[cand_q] && !res_vec[cand_q];
  assign cand_next   = (cand_q == LAST_SLOT) ? '0 : cand_q + 1'b1;
  assign ptr_next    = (ptr_q == LAST_SLOT) ? '0 : ptr_q + 1'b1;
  assign cand_onehot = {{(SLOT_COUNT-1){1'b0}}, 1'b1} << cand_q;

  // Sequencer, slot marks and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mask_q       <= '0;
      func_q       <= '0;
      id_q         <= '0;
      kind_q       <= 1'b0;
      obj_q        <= '0;
      bound_q      <= '0;
      fresh_q      <= '0;
      dup_q        <= '0;
      ptr_q        <= '0;
      cand_q       <= '0;
      cmp_idx_q    <= '0;
      cmp_vld_q    <= 1'b0;
      issue_q      <= '0;
      tried_q      <= '0;
      res_unit_q   <= '0;
      res_status_q <= STATUS_DONE;
      res_evv_q    <= 1'b0;
      res_evid_q   <= '0;
      res_obj_q    <= '0;
      res_kind_q   <= 1'b0;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
      m_user_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end

      // The output register fills from a finished result or empties when taken.
      if ((state_q == ST_RESP) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            func_q     <= in_func;
            id_q       <= in_id;
            kind_q     <= in_kind;
            obj_q      <= in_obj;
            res_evv_q  <= 1'b0;
            res_evid_q <= '0;
            res_obj_q  <= '0;
            res_kind_q <= 1'b0;
            issue_q    <= '0;
            cmp_vld_q  <= 1'b0;
            dup_q      <= '0;
            unique case (in_func)
              FUNC_BIND, FUNC_UNBIND_TEX: begin
                res_unit_q <= '0;
                if (in_id == '0) begin
                  res_status_q <= STATUS_INVALID;
                  state_q      <= ST_RESP;
                end else begin
                  res_status_q <= STATUS_DONE;
                  state_q      <= ST_SCAN;
                end
              end
              FUNC_UNBIND_SLOT: begin
                res_unit_q <= in_sidx;
                state_q    <= ST_RESP;
                if (in_range && bound_q[in_slot]) begin
                  bound_q[in_slot] <= 1'b0;
                  fresh_q[in_slot] <= 1'b0;
                  res_status_q     <= STATUS_DONE;
                end else begin
                  res_status_q <= STATUS_NOTBOUND;
                end
              end
              FUNC_UNBIND_ALL: begin
                res_unit_q   <= '0;
                res_status_q <= STATUS_DONE;
                state_q      <= ST_RESP;
                bound_q      <= '0;
                fresh_q      <= '0;
              end
              FUNC_STALE_SLOT: begin
                res_unit_q   <= in_sidx;
                res_status_q <= STATUS_DONE;
                state_q      <= ST_RESP;
                if (in_range) begin
                  fresh_q[in_slot] <= 1'b0;
                end
              end
              FUNC_STALE_ALL: begin
                res_unit_q   <= '0;
                res_status_q <= STATUS_DONE;
                state_q      <= ST_RESP;
                fresh_q      <= '0;
              end
              default: begin
                res_unit_q   <= '0;
                res_status_q <= STATUS_DONE;
                state_q      <= ST_RESP;
              end
            endcase
          end
        end

        ST_SCAN: begin
          // Issue one tag read a cycle; compare the previous one.
          if (issue_q < SLOT_CNT) begin
            issue_q   <= issue_q + 1'b1;
            cmp_idx_q <= issue_q[SLOT_W-1:0];
            cmp_vld_q <= 1'b1;
          end else begin
            cmp_vld_q <= 1'b0;
          end
          if (cmp_vld_q) begin
            if (func_q == FUNC_BIND) begin
              if (match && !res_vec[cmp_idx_q]) begin
                fresh_q[cmp_idx_q] <= 1'b1;
                res_unit_q         <= UNIT_W'(cmp_idx_q);
                res_status_q       <= STATUS_HIT;
                state_q            <= ST_RESP;
              end else begin
                dup_q[cmp_idx_q] <= match;
                if (scan_last) begin
                  cand_q  <= ptr_next;
                  tried_q <= '0;
                  state_q <= ST_FREE;
                end
              end
            end else begin
              if (match) begin
                bound_q[cmp_idx_q] <= 1'b0;
                fresh_q[cmp_idx_q] <= 1'b0;
                res_unit_q         <= UNIT_W'(cmp_idx_q);
                state_q            <= ST_RESP;
              end else if (scan_last) begin
                res_status_q <= STATUS_NOTBOUND;
                state_q      <= ST_RESP;
              end
            end
          end
        end

        ST_FREE: begin
          // Walk from one past the pointer for a stale, unreserved slot.
          if (cand_ok) begin
            state_q <= ST_EVRD;
          end else if (tried_q == LAST_TRY) begin
            res_status_q <= STATUS_FULL;
            state_q      <= ST_RESP;
          end else begin
            cand_q  <= cand_next;
            tried_q <= tried_q + 1'b1;
          end
        end

        ST_EVRD: begin
          state_q <= ST_COMMIT;
        end

        ST_COMMIT: begin
          // Evict the occupant, drop other copies of the tag, bind here.
          res_evv_q    <= bound_q[cand_q];
          res_evid_q   <= bound_q[cand_q] ? rdata_q : '0;
          bound_q      <= (bound_q & ~dup_q) | cand_onehot;
          fresh_q      <= (fresh_q & ~dup_q) | cand_onehot;
          ptr_q        <= cand_q;
          res_unit_q   <= UNIT_W'(cand_q);
          res_status_q <= STATUS_NEW;
          res_obj_q    <= obj_q;
          res_kind_q   <= kind_q;
          state_q      <= ST_RESP;
        end

        ST_RESP: begin
          if (out_free) begin
            m_data_q  <= {4'b0, res_obj_q, res_evid_q, res_unit_q};
            m_user_q  <= {res_kind_q, res_evv_q, res_status_q};
            state_q   <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // A fresh mark is only ever held by a bound slot.
  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fresh_q & ~bound_q) == '0)
    else $error("fresh mark on an unbound slot");

  // The round-robin pointer stays inside the table.
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ptr_q) < SLOT_COUNT)
    else $error("slot pointer out of range");

  // A bind never lands on a reserved or fresh slot.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT) |-> (!res_vec[cand_q] && !fresh_q[cand_q]))
    else $error("bind chose a reserved or fresh slot");

  // After a bind the chosen slot is bound and fresh.
  a_commit_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT) |=> (bound_q[$past(cand_q)] && fresh_q[$past(cand_q)]))
    else $error("bound slot not marked");

  // A pending result goes out as soon as the output register is empty.
  a_resp_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && !m_valid_q) |=> (m_valid_q && state_q == ST_IDLE))
    else $error("result not loaded into the output register");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import tusa_pkg::*;

  localparam int unsigned SLOTS        = SLOT_COUNT_DEF;
  localparam int unsigned DRAIN_CYCLES = 2 * SLOTS + 5;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned POOL_SIZE    = 20;

  // Function codes that the block does not define; they must answer done.
  localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TAG_W-1:0]  tex;
    logic              kind;
    logic [OBJ_W-1:0]  obj;
    logic [SIDX_W-1:0] slot;
  } request_t;

  typedef struct packed {
    logic [UNIT_W-1:0]   unit;
    logic [STATUS_W-1:0] status;
    logic                ev_valid;
    logic [TAG_W-1:0]    ev_id;
    logic [OBJ_W-1:0]    bind_obj;
    logic                bind_kind;
  } answer_t;

  // Mirror of the slot table; works out the answer to every accepted request.
  class slot_binding_scoreboard;
    logic [TAG_W-1:0]  tag [SLOTS];
    logic              kind_q [SLOTS];
    logic [OBJ_W-1:0]  obj_q [SLOTS];
    bit                bound [SLOTS];
    bit                fresh [SLOTS];
    int unsigned       ptr;
    logic [MASK_W-1:0] mask;
    answer_t           pending_answers [$];
    int unsigned       errors;
    int unsigned       requests;
    int unsigned       evictions;
    int unsigned       status_seen [8];

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        tag[i]    = '0;
        kind_q[i] = 1'b0;
        obj_q[i]  = '0;
        bound[i]  = 1'b0;
        fresh[i]  = 1'b0;
      end
      ptr       = 0;
      mask      = '0;
      errors    = 0;
      requests  = 0;
      evictions = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_mask(logic [MASK_W-1:0] value);
      mask = value;
    endfunction

    function bit reserved(int unsigned i);
      return (i < MASK_W) && mask[i];
    endfunction

    function void release_slot(int unsigned i);
      bound[i] = 1'b0;
      fresh[i] = 1'b0;
      tag[i]   = '0;
    endfunction

    function void note_request(request_t r);
      answer_t     a;
      bit          found;
      int unsigned c;
      a        = '0;
      a.status = STATUS_DONE;
      found    = 1'b0;
      if (ptr >= SLOTS) ptr = 0;
      unique case (r.func)
        FUNC_BIND: begin
          if (r.tex == '0) begin
            a.status = STATUS_INVALID;
          end else begin
            // A hit counts only in a slot that is not reserved.
            for (int i = 0; i < SLOTS; i++) begin
              if (!found && bound[i] && tag[i] == r.tex && !reserved(i)) begin
                fresh[i] = 1'b1;
                a.unit   = UNIT_W'(i);
                a.status = STATUS_HIT;
                found    = 1'b1;
              end
            end
            if (!found) begin
              // Round-robin search from one past the pointer for a stale, free slot.
              a.status = STATUS_FULL;
              for (int k = 1; k <= SLOTS; k++) begin
                c = (ptr + k) % SLOTS;
                if (!fresh[c] && !reserved(c)) begin
                  if (bound[c]) begin
                    a.ev_valid = 1'b1;
                    a.ev_id    = tag[c];
                  end
                  // Drop any reserved copy so that each tag lives in one slot.
                  for (int i = 0; i < SLOTS; i++)
                    if (i != c && bound[i] && tag[i] == r.tex) release_slot(i);
                  tag[c]      = r.tex;
                  kind_q[c]   = r.kind;
                  obj_q[c]    = r.obj;
                  bound[c]    = 1'b1;
                  fresh[c]    = 1'b1;
                  ptr         = c;
                  a.unit      = UNIT_W'(c);
                  a.status    = STATUS_NEW;
                  a.bind_obj  = r.obj;
                  a.bind_kind = r.kind;
                  break;
                end
              end
            end
          end
        end
        FUNC_UNBIND_TEX: begin
          if (r.tex == '0) begin
            a.status = STATUS_INVALID;
          end else begin
            a.status = STATUS_NOTBOUND;
            for (int i = 0; i < SLOTS; i++) begin
              if (bound[i] && tag[i] == r.tex) begin
                release_slot(i);
                a.unit   = UNIT_W'(i);
                a.status = STATUS_DONE;
                break;
              end
            end
          end
        end
        FUNC_UNBIND_SLOT: begin
          a.unit = r.slot;
          if (r.slot < SLOTS && bound[r.slot]) begin
            release_slot(r.slot);
            a.status = STATUS_DONE;
          end else begin
            a.status = STATUS_NOTBOUND;
          end
        end
        FUNC_UNBIND_ALL: begin
          for (int i = 0; i < SLOTS; i++) release_slot(i);
        end
        FUNC_STALE_SLOT: begin
          a.unit = r.slot;
          if (r.slot < SLOTS) fresh[r.slot] = 1'b0;
        end
        FUNC_STALE_ALL: begin
          for (int i = 0; i < SLOTS; i++) fresh[i] = 1'b0;
        end
        default: ;
      endcase
      requests++;
      status_seen[a.status]++;
      if (a.ev_valid) evictions++;
      pending_answers.push_back(a);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
      answer_t want;
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual tdata %0h tuser %0h",
                 $time, tdata, tuser);
        return;
      end
      want = pending_answers.pop_front();
      compare_field("unit", 16'(want.unit), 16'(tdata[3:0]));
      compare_field("evicted_id", want.ev_id, tdata[19:4]);
      compare_field("bind_object", want.bind_obj, tdata[35:20]);
      compare_field("status", 16'(want.status), 16'(tuser[2:0]));
      compare_field("evicted_valid", 16'(want.ev_valid), 16'(tuser[3]));
      compare_field("bind_kind", 16'(want.bind_kind), 16'(tuser[4]));
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [MASK_W-1:0]      cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic [S_TUSER_W-1:0]   s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic [M_TUSER_W-1:0]   m_axis_tuser;

  slot_binding_scoreboard board = new();
  request_t               batch [$];
  logic [TAG_W-1:0]       tag_pool [POOL_SIZE];
  int unsigned            max_gap   = 0;
  int unsigned            max_stall = 0;
  int unsigned            mask_writes = 0;
  int unsigned            cycle_count = 0;

  texture_unit_slot_allocator #(.SLOT_COUNT(SLOTS)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic request_t make_request(logic [FUNC_W-1:0] func, logic [TAG_W-1:0] tex,
                                            logic kind, logic [OBJ_W-1:0] obj,
                                            logic [SIDX_W-1:0] slot);
    request_t r;
    r.func = func;
    r.tex  = tex;
    r.kind = kind;
    r.obj  = obj;
    r.slot = slot;
    return r;
  endfunction

  // Mostly binds of a small pool of tags, so that hits, evictions and full tables occur.
  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    int unsigned tex_pick;
    pick     = $urandom_range(99, 0);
    tex_pick = $urandom_range(99, 0);
    r.kind   = 1'($urandom_range(1, 0));
    r.obj    = OBJ_W'($urandom_range(16'hFFFF, 0));
    r.slot   = SIDX_W'($urandom_range(SLOTS - 1, 0));
    if (tex_pick < 85)      r.tex = tag_pool[$urandom_range(POOL_SIZE - 1, 0)];
    else if (tex_pick < 97) r.tex = TAG_W'($urandom_range(16'hFFFF, 0));
    else                    r.tex = '0;
    if (pick < 50 || pick >= 98) r.func = FUNC_BIND;
    else if (pick < 58)          r.func = FUNC_UNBIND_TEX;
    else if (pick < 66)          r.func = FUNC_UNBIND_SLOT;
    else if (pick < 68)          r.func = FUNC_UNBIND_ALL;
    else if (pick < 86)          r.func = FUNC_STALE_SLOT;
    else if (pick < 96)          r.func = FUNC_STALE_ALL;
    else                         r.func = $urandom_range(1, 0) ? FUNC_SPARE_6 : FUNC_SPARE_7;
    return r;
  endfunction

  // Presents one request after a random gap and waits for it to be taken.
  task automatic send_request(request_t r);
    int unsigned gap;
    gap = $urandom_range(max_gap, 0);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W - 36){1'b0}}, r.slot, r.obj, r.tex};
    s_axis_tuser  <= {r.kind, r.func};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(r);
  endtask

  task automatic flush_batch();
    foreach (batch[i]) send_request(batch[i]);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    batch.delete();
  endtask

  task automatic wait_idle();
    while (board.pending_answers.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // The mask is changed only once every outstanding request has been answered.
  task automatic write_mask(logic [MASK_W-1:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    board.set_mask(value);
    mask_writes++;
  endtask

  // Result side: a random stall before each result, then ready until it is taken.
  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      stall = $urandom_range(max_stall, 0);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      board.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // Stimulus.
  initial begin : stimulus
    logic [MASK_W-1:0] phase_mask [6];
    int unsigned       phase_items [6];
    int unsigned       phase_gap [6];
    int unsigned       phase_stall [6];
    phase_mask  = '{16'h0000, 16'h0000, 16'hFFFF, 16'h8001, 16'h0000, 16'h0000};
    phase_items = '{140, 140, 40, 140, 140, 150};
    phase_gap   = '{10, 0, 10, 0, 3, 10};
    phase_stall = '{10, 0, 0, 10, 3, 10};
    phase_mask[1] = MASK_W'($urandom_range(16'hFFFF, 0));
    phase_mask[4] = MASK_W'($urandom_range(16'hFFFF, 0));
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: invalid handles, hit, misses, empty slot, spare codes.
    max_gap   = 2;
    max_stall = 2;
    write_mask(16'h0000);
    batch.push_back(make_request(FUNC_BIND, 16'h0000, 1'b0, 16'h0000, 4'd0));
    batch.push_back(make_request(FUNC_UNBIND_TEX, 16'h0000, 1'b1, 16'hFFFF, 4'd15));
    batch.push_back(make_request(FUNC_BIND, 16'hFFFF, 1'b1, 16'hFFFF, 4'd15));
    batch.push_back(make_request(FUNC_BIND, 16'hFFFF, 1'b0, 16'h0000, 4'd0));
    batch.push_back(make_request(FUNC_UNBIND_TEX, 16'h8000, 1'b0, 16'h1234, 4'd3));
    batch.push_back(make_request(FUNC_UNBIND_SLOT, 16'h0001, 1'b0, 16'h0000, 4'd15));
    batch.push_back(make_request(FUNC_STALE_SLOT, 16'h0000, 1'b0, 16'h0000, 4'd0));
    batch.push_back(make_request(FUNC_SPARE_6, 16'hFFFF, 1'b1, 16'hFFFF, 4'd15));
    batch.push_back(make_request(FUNC_SPARE_7, 16'hFFFF, 1'b1, 16'hFFFF, 4'd15));
    batch.push_back(make_request(FUNC_STALE_ALL, 16'h0000, 1'b0, 16'h0000, 4'd0));
    flush_batch();

    // Directed: the only holder of a tag becomes reserved, so the bind moves it.
    write_mask(16'h0002);
    batch.push_back(make_request(FUNC_BIND, 16'hFFFF, 1'b0, 16'h5A5A, 4'd0));
    batch.push_back(make_request(FUNC_UNBIND_SLOT, 16'h0000, 1'b0, 16'h0000, 4'd2));
    flush_batch();

    // Directed: four usable slots fill up, then a stale slot is evicted.
    write_mask(16'hFFF0);
    batch.push_back(make_request(FUNC_BIND, 16'h0001, 1'b0, 16'h0001, 4'd0));
    batch.push_back(make_request(FUNC_BIND, 16'h0002, 1'b1, 16'h0002, 4'd0));
    batch.push_back(make_request(FUNC_BIND, 16'h0004, 1'b0, 16'h0004, 4'd0));
    batch.push_back(make_request(FUNC_BIND, 16'h0008, 1'b1, 16'h0008, 4'd0));
    batch.push_back(make_request(FUNC_BIND, 16'h0010, 1'b0, 16'h0010, 4'd0));
    batch.push_back(make_request(FUNC_STALE_SLOT, 16'h0000, 1'b0, 16'h0000, 4'd0));
    batch.push_back(make_request(FUNC_BIND, 16'h0010, 1'b1, 16'hABCD, 4'd0));
    batch.push_back(make_request(FUNC_UNBIND_ALL, 16'h0000, 1'b0, 16'h0000, 4'd0));
    flush_batch();

    // Random phases, each with its own mask and idling pattern.
    for (int p = 0; p < 6; p++) begin
      write_mask(phase_mask[p]);
      max_gap   = phase_gap[p];
      max_stall = phase_stall[p];
      foreach (tag_pool[i]) tag_pool[i] = TAG_W'($urandom_range(16'hFFFF, 1));
      repeat (phase_items[p]) batch.push_back(random_request());
      flush_batch();
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests over %0d mask settings, %0d of them evicting a texture.",
             board.requests, mask_writes, board.evictions);
    $display("Answers: hit %0d, new %0d, full %0d, not bound %0d, invalid %0d, done %0d.",
             board.status_seen[STATUS_HIT], board.status_seen[STATUS_NEW],
             board.status_seen[STATUS_FULL], board.status_seen[STATUS_NOTBOUND],
             board.status_seen[STATUS_INVALID], board.status_seen[STATUS_DONE]);
    if (board.errors == 0 && board.pending_answers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
